>>> rtl/lnhf_pkg.sv
package lnhf_pkg;

  localparam int LIST_INDEX_BITS = 16;

  localparam int WIRE_W  = 13;
  localparam int TIME_W  = 18;
  localparam int IDX_W   = 16;
  localparam int SLOPE_W = 24;
  localparam int SCALE_W = 16;
  localparam int LIMIT_W = 16;

  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = ADDR_W - 2;

  localparam int DW_W        = WIRE_W + 1;
  localparam int DT_W        = TIME_W + 1;
  localparam int PROD_W      = SLOPE_W + DT_W;
  localparam int P_SHIFT     = 12;
  localparam int N_W         = PROD_W + P_SHIFT;
  localparam int MAG_W       = N_W - 1;
  localparam int ONE_SHIFT   = 32;
  localparam int DEN_W       = 2 * SLOPE_W - 1;
  localparam int Q_W         = 31;
  localparam int FRAC_W      = 16;
  localparam int FEED_SRC_W  = Q_W - FRAC_W;
  localparam int U_W         = Q_W + 1;
  localparam int VPROD_W     = SLOPE_W + Q_W;
  localparam int SPROD_W     = Q_W + SCALE_W;
  localparam int RES_W       = 34;
  localparam int RM_W        = 32;
  localparam int RPROD_W     = RM_W + SCALE_W;
  localparam int SCALE_SHIFT = 20;
  localparam int C_W         = 28;
  localparam int SQ_W        = 2 * C_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int LIM_SHIFT   = 4;
  localparam int LIM_W       = LIMIT_W + LIM_SHIFT;
  localparam int LIM_SQ_W    = 2 * LIM_W;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(4096);

  localparam int KEEP_IDX_W = (LIST_INDEX_BITS < IDX_W) ? LIST_INDEX_BITS : IDX_W;
  localparam logic [IDX_W:0] IDX_MASK_FULL = (IDX_W + 1)'(1) << KEEP_IDX_W;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(IDX_MASK_FULL - 1'b1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LINE_SLOPE   = 3'd0,
    REG_START_WIRE   = 3'd1,
    REG_START_TIME   = 3'd2,
    REG_ALONG_LIMIT  = 3'd3,
    REG_ACROSS_LIMIT = 3'd4,
    REG_WIRE_SCALE   = 3'd5,
    REG_TIME_SCALE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic [SLOPE_W-1:0]        slope_mag;
    logic [DEN_W-1:0]          den;
    logic [WIRE_W-1:0]         start_wire;
    logic [TIME_W-1:0]         start_time;
    logic [SCALE_W-1:0]        wire_scale;
    logic [SCALE_W-1:0]        time_scale;
    logic [LIM_SQ_W-1:0]       along_sq;
    logic [LIM_SQ_W-1:0]       across_sq;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]       idx;
    logic signed [DW_W-1:0] dw;
    logic signed [DT_W-1:0] dt;
    logic                   neg;
  } pass_t;

  typedef struct packed {
    pass_t            pass;
    logic [MAG_W-1:0] mag;
  } front_t;

  typedef struct packed {
    pass_t          pass;
    logic [Q_W-1:0] q;
  } quo_t;

endpackage

>>> rtl/lnhf_cfg.sv
module lnhf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lnhf_pkg::ADDR_W-1:0]  paddr,
  input  logic [lnhf_pkg::DATA_W-1:0]  pwdata,
  output logic [lnhf_pkg::DATA_W-1:0]  prdata,
  output lnhf_pkg::cfg_t               cfg
);
  import lnhf_pkg::*;

  logic [SLOPE_W-1:0]          line_slope;
  logic [WIRE_W-1:0]           start_wire;
  logic [TIME_W-1:0]           start_time;
  logic [LIMIT_W-1:0]          along_limit;
  logic [LIMIT_W-1:0]          across_limit;
  logic [SCALE_W-1:0]          wire_scale;
  logic [SCALE_W-1:0]          time_scale;
  logic                        wr;
  reg_idx_t                    idx;
  logic signed [2*SLOPE_W-1:0] slope_sq;
  logic [LIM_W-1:0]            along_lim;
  logic [LIM_W-1:0]            across_lim;
  logic [DEN_W-1:0]            den;
  logic [SLOPE_W-1:0]          slope_mag;
  logic [LIM_SQ_W-1:0]         along_sq;
  logic [LIM_SQ_W-1:0]         across_sq;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_slope   <= '0;
      start_wire   <= '0;
      start_time   <= '0;
      along_limit  <= '0;
      across_limit <= '0;
      wire_scale   <= SCALE_RST;
      time_scale   <= SCALE_RST;
    end else if (wr) begin
      case (idx)
        REG_LINE_SLOPE:   line_slope   <= pwdata[SLOPE_W-1:0];
        REG_START_WIRE:   start_wire   <= pwdata[WIRE_W-1:0];
        REG_START_TIME:   start_time   <= pwdata[TIME_W-1:0];
        REG_ALONG_LIMIT:  along_limit  <= pwdata[LIMIT_W-1:0];
        REG_ACROSS_LIMIT: across_limit <= pwdata[LIMIT_W-1:0];
        REG_WIRE_SCALE:   wire_scale   <= pwdata[SCALE_W-1:0];
        REG_TIME_SCALE:   time_scale   <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINE_SLOPE:   prdata = DATA_W'(line_slope);
      REG_START_WIRE:   prdata = DATA_W'(start_wire);
      REG_START_TIME:   prdata = DATA_W'(start_time);
      REG_ALONG_LIMIT:  prdata = DATA_W'(along_limit);
      REG_ACROSS_LIMIT: prdata = DATA_W'(across_limit);
      REG_WIRE_SCALE:   prdata = DATA_W'(wire_scale);
      REG_TIME_SCALE:   prdata = DATA_W'(time_scale);
      default:          prdata = '0;
    endcase
  end

  // precompute terms that depend on the registers only
  assign slope_sq   = (2*SLOPE_W)'($signed(line_slope)) * (2*SLOPE_W)'($signed(line_slope));
  assign along_lim  = {along_limit, LIM_SHIFT'(0)};
  assign across_lim = {across_limit, LIM_SHIFT'(0)};

  always_ff @(posedge clk) begin
    den       <= DEN_W'(slope_sq) + (DEN_W'(1) << ONE_SHIFT);
    slope_mag <= line_slope[SLOPE_W-1] ? SLOPE_W'(-line_slope) : line_slope;
    along_sq  <= LIM_SQ_W'(along_lim) * LIM_SQ_W'(along_lim);
    across_sq <= LIM_SQ_W'(across_lim) * LIM_SQ_W'(across_lim);
  end

  always_comb begin
    cfg.slope      = $signed(line_slope);
    cfg.slope_mag  = slope_mag;
    cfg.den        = den;
    cfg.start_wire = start_wire;
    cfg.start_time = start_time;
    cfg.wire_scale = wire_scale;
    cfg.time_scale = time_scale;
    cfg.along_sq   = along_sq;
    cfg.across_sq  = across_sq;
  end

endmodule

>>> rtl/lnhf_front.sv
module lnhf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [lnhf_pkg::WIRE_W-1:0]  hit_wire,
  input  logic [lnhf_pkg::TIME_W-1:0]  hit_time,
  input  logic [lnhf_pkg::IDX_W-1:0]   hit_index,
  input  lnhf_pkg::cfg_t               cfg,
  output logic                         out_valid,
  output lnhf_pkg::front_t             out_data
);
  import lnhf_pkg::*;

  logic                     v1, v2, v3;
  logic [IDX_W-1:0]         idx1, idx2, idx3;
  logic signed [DW_W-1:0]   dw1, dw2, dw3;
  logic signed [DT_W-1:0]   dt1, dt2, dt3;
  logic signed [PROD_W-1:0] p2;
  logic signed [N_W-1:0]    n3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= hit_index;
      dw1  <= DW_W'(hit_wire) - DW_W'(cfg.start_wire);
      dt1  <= DT_W'(hit_time) - DT_W'(cfg.start_time);

      idx2 <= idx1;
      dw2  <= dw1;
      dt2  <= dt1;
      p2   <= PROD_W'($signed(cfg.slope)) * PROD_W'(dt1);

      idx3 <= idx2;
      dw3  <= dw2;
      dt3  <= dt2;
      n3   <= (N_W'(dw2) <<< ONE_SHIFT) + (N_W'(p2) <<< P_SHIFT);

      out_data.pass.idx <= idx3;
      out_data.pass.dw  <= dw3;
      out_data.pass.dt  <= dt3;
      out_data.pass.neg <= n3[N_W-1];
      out_data.mag      <= n3[N_W-1] ? MAG_W'(-n3) : MAG_W'(n3);
    end
  end

endmodule

>>> rtl/lnhf_div.sv
module lnhf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  lnhf_pkg::front_t            in_data,
  input  logic [lnhf_pkg::DEN_W-1:0]  den,
  output logic                        out_valid,
  output lnhf_pkg::quo_t              out_data
);
  import lnhf_pkg::*;

  logic             v    [Q_W];
  pass_t            pass [Q_W];
  logic [Q_W-1:0]   q    [Q_W];
  logic [DEN_W-1:0] rem  [Q_W-1];
  logic [Q_W-1:0]   feed [Q_W-1];
  logic [DEN_W-1:0] rem_init;
  logic [Q_W-1:0]   feed_init;

  assign rem_init  = DEN_W'(in_data.mag >> FEED_SRC_W);
  assign feed_init = {in_data.mag[FEED_SRC_W-1:0], FRAC_W'(0)};

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic             vin;
    pass_t            pin;
    logic [Q_W-1:0]   qin;
    logic [DEN_W-1:0] rin;
    logic [Q_W-1:0]   fin;
    logic [DEN_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign pin = in_data.pass;
      assign qin = '0;
      assign rin = rem_init;
      assign fin = feed_init;
    end else begin : g_next
      assign vin = v[k-1];
      assign pin = pass[k-1];
      assign qin = q[k-1];
      assign rin = rem[k-1];
      assign fin = feed[k-1];
    end

    assign trial = {rin, fin[Q_W-1]};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pass[k] <= pin;
        q[k]    <= {qin[Q_W-2:0], take};
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k]  <= take ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
          feed[k] <= fin << 1;
        end
      end
    end
  end

  assign out_valid = v[Q_W-1];

  always_comb begin
    out_data.pass = pass[Q_W-1];
    out_data.q    = q[Q_W-1];
  end

endmodule

>>> rtl/lnhf_back.sv
module lnhf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  lnhf_pkg::quo_t              in_data,
  input  lnhf_pkg::cfg_t              cfg,
  output logic                        out_valid,
  output logic [lnhf_pkg::IDX_W-1:0]  out_idx,
  output logic                        out_keep
);
  import lnhf_pkg::*;

  function automatic logic [SQ_W-1:0] square(input logic [C_W-1:0] c);
    square = SQ_W'(c) * SQ_W'(c);
  endfunction

  logic                      v1, v2, v3, v4, v5, v6;
  logic [IDX_W-1:0]          idx1, idx2, idx3, idx4, idx5, idx6;
  logic signed [DW_W-1:0]    dw1;
  logic signed [DT_W-1:0]    dt1;
  logic signed [U_W-1:0]     u1;
  logic                      vneg1;
  logic [VPROD_W-1:0]        vprod1;
  logic [SPROD_W-1:0]        uw1;
  logic [Q_W-1:0]            vm;
  logic [Q_W-1:0]            vmag2;
  logic signed [RES_W-1:0]   rw2, rt2;
  logic [SQ_W-1:0]           uw_sq2, uw_sq3, uw_sq4;
  logic [RM_W-1:0]           rwm3, rtm3;
  logic [SPROD_W-1:0]        vt3;
  logic [RPROD_W-1:0]        rw_p4, rt_p4;
  logic [SQ_W-1:0]           vt_sq4;
  logic [SUM_W-1:0]          along5;
  logic [SQ_W-1:0]           rw_sq5, rt_sq5;
  logic                      along_ok6;
  logic [SUM_W-1:0]          across6;

  assign vm = Q_W'(vprod1 >> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1   <= in_data.pass.idx;
      dw1    <= in_data.pass.dw;
      dt1    <= in_data.pass.dt;
      u1     <= in_data.pass.neg ? -U_W'(in_data.q) : U_W'(in_data.q);
      vneg1  <= in_data.pass.neg ^ cfg.slope[SLOPE_W-1];
      vprod1 <= VPROD_W'(cfg.slope_mag) * VPROD_W'(in_data.q);
      uw1    <= SPROD_W'(in_data.q) * SPROD_W'(cfg.wire_scale);

      idx2   <= idx1;
      vmag2  <= vm;
      rw2    <= (RES_W'(dw1) <<< FRAC_W) - RES_W'(u1);
      rt2    <= vneg1 ? (RES_W'(dt1) <<< P_SHIFT) + RES_W'(vm)
                      : (RES_W'(dt1) <<< P_SHIFT) - RES_W'(vm);
      uw_sq2 <= square(C_W'(uw1 >> SCALE_SHIFT));

      idx3   <= idx2;
      rwm3   <= rw2[RES_W-1] ? RM_W'(-rw2) : RM_W'(rw2);
      rtm3   <= rt2[RES_W-1] ? RM_W'(-rt2) : RM_W'(rt2);
      vt3    <= SPROD_W'(vmag2) * SPROD_W'(cfg.time_scale);
      uw_sq3 <= uw_sq2;

      idx4   <= idx3;
      rw_p4  <= RPROD_W'(rwm3) * RPROD_W'(cfg.wire_scale);
      rt_p4  <= RPROD_W'(rtm3) * RPROD_W'(cfg.time_scale);
      vt_sq4 <= square(C_W'(vt3 >> SCALE_SHIFT));
      uw_sq4 <= uw_sq3;

      idx5   <= idx4;
      along5 <= SUM_W'(uw_sq4) + SUM_W'(vt_sq4);
      rw_sq5 <= square(C_W'(rw_p4 >> SCALE_SHIFT));
      rt_sq5 <= square(C_W'(rt_p4 >> SCALE_SHIFT));

      idx6      <= idx5;
      along_ok6 <= along5 < SUM_W'(cfg.along_sq);
      across6   <= SUM_W'(rw_sq5) + SUM_W'(rt_sq5);

      out_idx  <= idx6;
      out_keep <= along_ok6 && (across6 < SUM_W'(cfg.across_sq));
    end
  end

endmodule

>>> rtl/line_neighbourhood_hit_filter.sv
// Channel  Dir  Handshake             Payload
// hit      in   in_valid / in_ready   hit_wire, hit_time, hit_index
// result   out  out_valid / out_ready hit_index_out, keep_hit
// config   in   psel, penable, pready paddr, pwdata (write), prdata (read)
//
// One transaction per cycle while in_ready is high; a result appears once its hit has passed
// 4 front stages, a 31-stage divider retiring one quotient bit per stage, 7 back stages
// and the output register, the first stage loading at the accepting edge.
// Synchronous reset clears every valid bit and loads the register defaults.
// A result not taken parks the next one in a skid register; only then does in_ready
// drop and the whole pipeline hold in place.
module line_neighbourhood_hit_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lnhf_pkg::ADDR_W-1:0]  paddr,
  input  logic [lnhf_pkg::DATA_W-1:0]  pwdata,
  output logic [lnhf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lnhf_pkg::WIRE_W-1:0]  hit_wire,
  input  logic [lnhf_pkg::TIME_W-1:0]  hit_time,
  input  logic [lnhf_pkg::IDX_W-1:0]   hit_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lnhf_pkg::IDX_W-1:0]   hit_index_out,
  output logic                         keep_hit
);
  import lnhf_pkg::*;

  cfg_t             cfg;
  logic             en;
  logic             front_valid;
  front_t           front_data;
  logic             div_valid;
  quo_t             div_data;
  logic             back_valid;
  logic [IDX_W-1:0] back_idx;
  logic             back_keep;
  logic             push;
  logic             pop;
  logic             head_valid;
  logic [IDX_W-1:0] head_idx;
  logic             head_keep;
  logic             skid_valid;
  logic [IDX_W-1:0] skid_idx;
  logic             skid_keep;

  assign pready   = 1'b1;
  assign en       = !skid_valid;
  assign in_ready = en;

  lnhf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lnhf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .hit_wire  (hit_wire),
    .hit_time  (hit_time),
    .hit_index (hit_index),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  lnhf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .den       (cfg.den),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  lnhf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .cfg       (cfg),
    .out_valid (back_valid),
    .out_idx   (back_idx),
    .out_keep  (back_keep)
  );

  assign push = back_valid && en;
  assign pop  = head_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      skid_valid <= 1'b0;
    end else if (pop) begin
      head_valid <= push;
    end else if (push) begin
      head_valid <= 1'b1;
      skid_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      head_idx  <= skid_idx;
      head_keep <= skid_keep;
    end else if (push && (pop || !head_valid)) begin
      head_idx  <= back_idx;
      head_keep <= back_keep;
    end else if (push) begin
      skid_idx  <= back_idx;
      skid_keep <= back_keep;
    end
  end

  assign out_valid     = head_valid;
  assign hit_index_out = head_idx & IDX_MASK;
  assign keep_hit      = head_keep;

endmodule

>>> rtl/lnhf_checker.sv
module lnhf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lnhf_pkg::IDX_W-1:0]  hit_index_out,
  input logic                        keep_hit
);
  import lnhf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_index_out) && $stable(keep_hit))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_stall_has_head: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without a prior output stall");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> $stable(rst))
    else $error("transaction accepted across reset edge");

endmodule

bind line_neighbourhood_hit_filter lnhf_checker u_lnhf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit_index_out (hit_index_out),
  .keep_hit      (keep_hit)
);
